@@ rtl/ipv4dq_pkg.sv @@
package ipv4dq_pkg;

    // character codes and parse limits
    localparam logic [7:0]  CH_DOT      = 8'h2E;
    localparam logic [7:0]  CH_ZERO     = 8'h30;
    localparam logic [7:0]  CH_NINE     = 8'h39;
    localparam logic [11:0] DIGIT_BASE  = 12'd10;
    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [1:0]  DIGITS_MAX  = 2'd3;
    localparam logic [1:0]  DOTS_NEEDED = 2'd3;

    // octet slots in the done_octets word
    localparam logic [1:0] OCTET_FIRST  = 2'd0;
    localparam logic [1:0] OCTET_SECOND = 2'd1;
    localparam logic [1:0] OCTET_THIRD  = 2'd2;

    // running parse state for one string
    typedef struct packed {
        logic [1:0]  octet_index;
        logic [7:0]  octet_value;
        logic [1:0]  digit_count;
        logic        error_seen;
        logic [23:0] done_octets;
    } parse_state_t;

    // one result item
    typedef struct packed {
        logic        parse_ok;
        logic [31:0] address;
    } parse_result_t;

    localparam parse_state_t STATE_CLEAR = '{
        octet_index: 2'd0,
        octet_value: 8'd0,
        digit_count: 2'd0,
        error_seen:  1'b0,
        done_octets: 24'd0
    };

endpackage

@@ rtl/ipv4dq_step.sv @@
module ipv4dq_step
(
    input  ipv4dq_pkg::parse_state_t  cur,
    input  logic [7:0]                char_code,
    output ipv4dq_pkg::parse_state_t  nxt,
    output ipv4dq_pkg::parse_result_t result
);

    logic        is_digit;
    logic        is_dot;
    logic [11:0] value_next;

    assign is_digit   = (char_code >= ipv4dq_pkg::CH_ZERO) && (char_code <= ipv4dq_pkg::CH_NINE);
    assign is_dot     = (char_code == ipv4dq_pkg::CH_DOT);
    // value * 10 + digit, at most 2559
    assign value_next = 12'(cur.octet_value) * ipv4dq_pkg::DIGIT_BASE
                        + {8'd0, char_code[3:0]};

    // per-character state update
    always_comb
    begin
        nxt = cur;
        if (!cur.error_seen)
        begin
            if (is_digit)
            begin
                if ((cur.digit_count >= ipv4dq_pkg::DIGITS_MAX)
                    || (value_next > ipv4dq_pkg::OCTET_MAX))
                begin
                    nxt.error_seen = 1'b1;
                end
                else
                begin
                    nxt.octet_value = value_next[7:0];
                    nxt.digit_count = cur.digit_count + 2'd1;
                end
            end
            else if (is_dot)
            begin
                if ((cur.digit_count == 2'd0) || (cur.octet_index >= ipv4dq_pkg::DOTS_NEEDED))
                begin
                    nxt.error_seen = 1'b1;
                end
                else
                begin
                    case (cur.octet_index)
                        ipv4dq_pkg::OCTET_FIRST:  nxt.done_octets[7:0]   = cur.octet_value;
                        ipv4dq_pkg::OCTET_SECOND: nxt.done_octets[15:8]  = cur.octet_value;
                        ipv4dq_pkg::OCTET_THIRD:  nxt.done_octets[23:16] = cur.octet_value;
                        default:                  nxt.done_octets        = cur.done_octets;
                    endcase
                    nxt.octet_index = cur.octet_index + 2'd1;
                    nxt.octet_value = 8'd0;
                    nxt.digit_count = 2'd0;
                end
            end
            else
            begin
                nxt.error_seen = 1'b1;
            end
        end
    end

    // end-of-string verdict on the updated state
    always_comb
    begin
        result.parse_ok = !nxt.error_seen && (nxt.octet_index == ipv4dq_pkg::DOTS_NEEDED)
                          && (nxt.digit_count != 2'd0);
        result.address  = result.parse_ok ? {nxt.octet_value, nxt.done_octets} : 32'd0;
    end

endmodule

@@ rtl/ipv4dq_out_reg.sv @@
module ipv4dq_out_reg
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  ipv4dq_pkg::parse_result_t load_data,
    output logic                      load_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ipv4dq_pkg::parse_result_t out_data
);

    logic                      valid_reg;
    logic                      valid_next;
    ipv4dq_pkg::parse_result_t data_reg;

    // free when empty or the held result leaves this cycle
    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && load_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/ipv4_dotted_quad_parser_top.sv @@
// a last character passes the input register, its result the m_axis output register
// throughput: one character per cycle unless a last character is held back
// only a last character waits in the input register while a result is held and not taken
// reset: rst_n is asynchronous, active low; it empties both registers and clears the
// parse state, so the next character starts a new string
module ipv4_dotted_quad_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] address
    output logic [0:0]  m_axis_tuser    // [0] parse_ok
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [7:0]                in_char_reg;
    logic                      in_last_reg;
    logic                      advance;
    logic                      out_load_ready;
    ipv4dq_pkg::parse_state_t  state_reg;
    ipv4dq_pkg::parse_state_t  state_next;
    ipv4dq_pkg::parse_state_t  step_state;
    ipv4dq_pkg::parse_result_t step_result;
    ipv4dq_pkg::parse_result_t out_data;

    // a held character moves on unless it is last and the result slot is busy
    assign advance       = in_valid_reg && (!in_last_reg || out_load_ready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    ipv4dq_step u_step
    (
        .cur       (state_reg),
        .char_code (in_char_reg),
        .nxt       (step_state),
        .result    (step_result)
    );

    // parse state clears after the last character
    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = in_last_reg ? ipv4dq_pkg::STATE_CLEAR : step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipv4dq_pkg::STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    ipv4dq_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && in_last_reg),
        .load_data  (step_result),
        .load_ready (out_load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data)
    );

    assign m_axis_tdata = out_data.address;
    assign m_axis_tuser = out_data.parse_ok;

endmodule

@@ rtl/ipv4dq_checker.sv @@
module ipv4dq_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

    // a failed parse reports a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
    else $error("failed parse with nonzero address");

    // input back-pressure only comes from a held result that is not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

    // reset empties the result register
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind ipv4_dotted_quad_parser_top ipv4dq_checker u_ipv4dq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
